[hdl/lhau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhau_pkg
// Shared types and constants of the latency histogram accumulator.
// ----------------------------------------------------------------------------
package lhau_pkg;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_LOAD   = 2'd1,
        OP_DRAIN  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    localparam logic [1:0] CFG_TICK_FREQ    = 2'd0;
    localparam logic [1:0] CFG_SERIES_COUNT = 2'd1;
    localparam logic [1:0] CFG_BUCKET_COUNT = 2'd2;

    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

    // effective configuration as seen by the datapath
    typedef struct packed {
        logic [39:0] freq;
        logic [3:0]  used_series;
        logic [3:0]  used_buckets;
    } cfg_t;

    // queued command; idx is the series or the bound slot, data the bytes or the bound
    typedef struct packed {
        opcode_t     op;
        logic [2:0]  idx;
        logic [63:0] ticks;
        logic [63:0] data;
    } cmd_t;

endpackage

[hdl/latency_histogram_accumulator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// latency_histogram_accumulator_unit
// Per-series latency histogram with tick to ns conversion and drain.
//
//   channel  dir  handshake         payload
//   s_*      in   s_valid/s_ready   opcode, series, ticks, bytes, slot, bound
//   m_*      out  m_valid/m_ready   series, bucket, calls, ticks, bytes, last
//   cfg_*    in   cfg_wr_en         cfg_index, cfg_data
//
// Record in the back end: two 32x30 multiplies, a radix-4 divider, bucket pick,
// cell read-modify-write. Load: the bound is written as the command is popped.
// Drain: each cell is read (ST_DR_READ), then put out (ST_DR_OUT).
// A 2-word queue lets input be taken while the back end is busy.
// Reset clears the cell valid bits at once; no clearing pass is needed.
// A stalled m_ready holds the drain at its current cell.
// ----------------------------------------------------------------------------
module latency_histogram_accumulator_unit import lhau_pkg::*; #(
    parameter int MAX_SERIES  = 8,
    parameter int MAX_BUCKETS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [39:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [2:0]  s_series_index,
    input  wire logic [63:0] s_duration_ticks,
    input  wire logic [63:0] s_byte_count,
    input  wire logic [2:0]  s_bound_slot,
    input  wire logic [63:0] s_bound_nanoseconds,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_out_series,
    output logic [2:0]       m_out_bucket,
    output logic [63:0]      m_call_count,
    output logic [63:0]      m_tick_sum,
    output logic [63:0]      m_byte_sum,
    output logic             m_last
);

    logic [39:0] freq_reg;
    logic [3:0]  series_count_reg, bucket_count_reg;
    cfg_t        cfg;
    logic        q_valid, q_pop;
    cmd_t        q_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg         <= 40'd10000000;
            series_count_reg <= 4'd1;
            bucket_count_reg <= 4'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TICK_FREQ:    freq_reg <= cfg_data;
                CFG_SERIES_COUNT: series_count_reg <= cfg_data[3:0];
                CFG_BUCKET_COUNT: bucket_count_reg <= cfg_data[3:0];
                default:          freq_reg <= freq_reg;
            endcase
        end
    end

    always_comb begin
        cfg.freq = freq_reg;
        cfg.used_series = (series_count_reg > 4'(MAX_SERIES)) ? 4'(MAX_SERIES)
                                                             : series_count_reg;
        if (bucket_count_reg == 4'd0) cfg.used_buckets = 4'd1;
        else if (bucket_count_reg > 4'(MAX_BUCKETS)) cfg.used_buckets = 4'(MAX_BUCKETS);
        else cfg.used_buckets = bucket_count_reg;
    end

    lhau_front #(.MAX_BUCKETS(MAX_BUCKETS)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_opcode, .s_series_index,
        .s_duration_ticks, .s_byte_count, .s_bound_slot, .s_bound_nanoseconds,
        .cfg, .q_valid, .q_pop, .q_cmd
    );

    lhau_back #(.MAX_SERIES(MAX_SERIES), .MAX_BUCKETS(MAX_BUCKETS)) u_back (
        .aclk, .aresetn, .cfg, .q_valid, .q_pop, .q_cmd, .m_valid, .m_ready,
        .m_out_series, .m_out_bucket, .m_call_count, .m_tick_sum, .m_byte_sum,
        .m_last
    );

endmodule
`default_nettype wire

[hdl/lhau_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lhau_front
// Accepts input words, drops the ones that have no effect, queues the rest.
// ----------------------------------------------------------------------------
module lhau_front import lhau_pkg::*; #(
    parameter int MAX_BUCKETS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [2:0]  s_series_index,
    input  wire logic [63:0] s_duration_ticks,
    input  wire logic [63:0] s_byte_count,
    input  wire logic [2:0]  s_bound_slot,
    input  wire logic [63:0] s_bound_nanoseconds,
    input  wire cfg_t        cfg,
    output logic             q_valid,
    input  wire logic        q_pop,
    output cmd_t             q_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    opcode_t    op;
    logic       keep, push;
    cmd_t       new_cmd;

    always_comb begin
        op   = opcode_t'(s_opcode);
        keep = 1'b0;
        case (op)
            OP_RECORD: keep = {1'b0, s_series_index} < cfg.used_series;
            OP_LOAD:   keep = 4'(s_bound_slot) < 4'(MAX_BUCKETS);
            OP_DRAIN:  keep = 1'b1;
            default:   keep = 1'b0;
        endcase
        new_cmd.op    = op;
        new_cmd.idx   = (op == OP_LOAD) ? s_bound_slot : s_series_index;
        new_cmd.ticks = s_duration_ticks;
        new_cmd.data  = (op == OP_LOAD) ? s_bound_nanoseconds : s_byte_count;
    end

    assign s_ready = count_reg != 2'd2;
    assign push    = s_valid && s_ready && keep;
    assign q_valid = count_reg != 2'd0;
    assign q_cmd   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop && q_valid) rd_ptr_reg <= ~rd_ptr_reg;
            case ({push, q_pop && q_valid})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

[hdl/lhau_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lhau_back
// Executes queued commands: bound load, ns conversion, bucket pick, cell update, drain.
// ----------------------------------------------------------------------------
module lhau_back import lhau_pkg::*; #(
    parameter int MAX_SERIES  = 8,
    parameter int MAX_BUCKETS = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire cfg_t         cfg,
    input  wire logic         q_valid,
    output logic              q_pop,
    input  wire cmd_t         q_cmd,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [2:0]        m_out_series,
    output logic [2:0]        m_out_bucket,
    output logic [63:0]       m_call_count,
    output logic [63:0]       m_tick_sum,
    output logic [63:0]       m_byte_sum,
    output logic              m_last
);

    localparam int DEPTH = MAX_SERIES * MAX_BUCKETS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BIW   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_HI, ST_COMBINE, ST_DIVIDE, ST_ROUND,
        ST_PICK, ST_READ, ST_UPDATE, ST_DR_READ, ST_DR_OUT
    } state_t;

    function automatic logic [AW-1:0] cell_addr(input logic [2:0] s, input logic [2:0] b);
        int a;
        a = int'(s) * MAX_BUCKETS + int'(b);
        return AW'(a);
    endfunction

    state_t        state_reg;
    logic [63:0]   ticks_reg, data_reg;
    logic [2:0]    ser_reg, bkt_reg;
    logic [61:0]   p_lo_reg, p_hi_reg;
    logic [93:0]   dvd_reg;
    logic [39:0]   rem_reg;
    logic [63:0]   quo_reg;
    logic          ovf_reg;
    logic [5:0]    cnt_reg;
    logic [63:0]   ns_reg;
    logic [AW-1:0] addr_reg;
    logic [DEPTH-1:0] cell_vld_reg;
    logic          rvld_reg;
    logic [191:0]  rdata_reg;
    logic [63:0]   bound_reg [MAX_BUCKETS];
    logic [191:0]  cell_mem [DEPTH];

    logic          m_valid_reg, m_last_reg;
    logic [2:0]    m_series_reg, m_bucket_reg;
    logic [63:0]   m_calls_reg, m_ticks_reg, m_bytes_reg;

    // two restoring divide steps per cycle
    logic [40:0]   t1, t2, fz;
    logic          qb1, qb2;
    logic [39:0]   r1, r2;
    logic [2:0]    pick;
    logic [191:0]  base;
    logic          mem_we, last_cell, bkt_wrap;
    logic [2:0]    ser_nx, bkt_nx;

    always_comb begin
        fz  = {1'b0, cfg.freq};
        t1  = {rem_reg, dvd_reg[93]};
        qb1 = t1 >= fz;
        r1  = qb1 ? 40'(t1 - fz) : t1[39:0];
        t2  = {r1, dvd_reg[92]};
        qb2 = t2 >= fz;
        r2  = qb2 ? 40'(t2 - fz) : t2[39:0];
    end

    // first in-use bucket whose bound covers ns, else the last in-use one
    always_comb begin
        pick = 3'(cfg.used_buckets - 4'd1);
        for (int i = MAX_BUCKETS - 1; i >= 0; i--) begin
            if (4'(i) < cfg.used_buckets && ns_reg <= bound_reg[i]) pick = 3'(i);
        end
    end

    always_comb begin
        base      = rvld_reg ? rdata_reg : '0;
        mem_we    = state_reg == ST_UPDATE;
        last_cell = (4'(ser_reg) + 4'd1 == cfg.used_series) &&
                    (4'(bkt_reg) + 4'd1 == cfg.used_buckets);
        bkt_wrap  = 4'(bkt_reg) + 4'd1 == cfg.used_buckets;
        bkt_nx    = bkt_wrap ? 3'd0 : bkt_reg + 3'd1;
        ser_nx    = bkt_wrap ? ser_reg + 3'd1 : ser_reg;
    end

    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    // cell memory and bucket bounds
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cell_mem[addr_reg] <= {base[191:128] + 64'd1,
                                   base[127:64] + ticks_reg,
                                   base[63:0] + data_reg};
        end
        rdata_reg <= cell_mem[addr_reg];
        if (q_pop && q_cmd.op == OP_LOAD) begin
            bound_reg[q_cmd.idx[BIW-1:0]] <= q_cmd.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cell_vld_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            rvld_reg <= cell_vld_reg[addr_reg];
            // the drain state owns the output register while it runs
            if (m_ready && state_reg != ST_DR_OUT) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        ticks_reg <= q_cmd.ticks;
                        data_reg  <= q_cmd.data;
                        ser_reg   <= (q_cmd.op == OP_DRAIN) ? 3'd0 : q_cmd.idx;
                        p_lo_reg  <= q_cmd.ticks[31:0] * NS_PER_SEC;
                        case (q_cmd.op)
                            OP_RECORD: state_reg <= ST_MUL_HI;
                            OP_DRAIN: begin
                                bkt_reg <= 3'd0;
                                addr_reg <= cell_addr(3'd0, 3'd0);
                                if (cfg.used_series != 4'd0) state_reg <= ST_DR_READ;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_MUL_HI: begin
                    p_hi_reg  <= ticks_reg[63:32] * NS_PER_SEC;
                    state_reg <= ST_COMBINE;
                end
                ST_COMBINE: begin
                    dvd_reg   <= {p_hi_reg, 32'd0} + 94'(p_lo_reg);
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    ovf_reg   <= 1'b0;
                    cnt_reg   <= '0;
                    state_reg <= ST_DIVIDE;
                end
                ST_DIVIDE: begin
                    dvd_reg <= {dvd_reg[91:0], 2'b00};
                    rem_reg <= r2;
                    quo_reg <= {quo_reg[61:0], qb1, qb2};
                    ovf_reg <= ovf_reg | quo_reg[63] | quo_reg[62];
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd46) state_reg <= ST_ROUND;
                end
                ST_ROUND: begin
                    if (cfg.freq == '0) ns_reg <= '0;
                    else if (ovf_reg) ns_reg <= '1;
                    else if (rem_reg != '0 && quo_reg != '1) ns_reg <= quo_reg + 64'd1;
                    else ns_reg <= quo_reg;
                    state_reg <= ST_PICK;
                end
                ST_PICK: begin
                    addr_reg  <= cell_addr(ser_reg, pick);
                    state_reg <= ST_READ;
                end
                ST_READ: state_reg <= ST_UPDATE;
                ST_UPDATE: begin
                    cell_vld_reg[addr_reg] <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_DR_READ: state_reg <= ST_DR_OUT;
                ST_DR_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_series_reg <= ser_reg;
                        m_bucket_reg <= bkt_reg;
                        m_calls_reg  <= base[191:128];
                        m_ticks_reg  <= base[127:64];
                        m_bytes_reg  <= base[63:0];
                        m_last_reg   <= last_cell;
                        cell_vld_reg[addr_reg] <= 1'b0;
                        if (last_cell) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            ser_reg   <= ser_nx;
                            bkt_reg   <= bkt_nx;
                            addr_reg  <= cell_addr(ser_nx, bkt_nx);
                            state_reg <= ST_DR_READ;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_series = m_series_reg;
    assign m_out_bucket = m_bucket_reg;
    assign m_call_count = m_calls_reg;
    assign m_tick_sum   = m_ticks_reg;
    assign m_byte_sum   = m_bytes_reg;
    assign m_last       = m_last_reg;

endmodule
`default_nettype wire

[hdl/lhau_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lhau_checker
// Port-level checks of the histogram unit's result channel.
// ----------------------------------------------------------------------------
module lhau_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_out_series,
    input wire logic [2:0]  m_out_bucket,
    input wire logic [63:0] m_call_count,
    input wire logic [63:0] m_tick_sum,
    input wire logic [63:0] m_byte_sum,
    input wire logic        m_last
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_out_series) && $stable(m_out_bucket) &&
            $stable(m_call_count) && $stable(m_tick_sum) &&
            $stable(m_byte_sum) && $stable(m_last))
        else $error("result word changed while stalled");

    // an empty cell has had nothing added to it
    a_empty_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_call_count == 64'd0 |-> m_tick_sum == 64'd0 && m_byte_sum == 64'd0)
        else $error("cell with no calls carries nonzero sums");

endmodule

bind latency_histogram_accumulator_unit lhau_checker u_lhau_checker (.*);
`default_nettype wire
